// ----- sv/ba_pkg.sv -----
// ----------------------------------------------------------------------------
// ba_pkg: shared constants, types and tree helpers
// Sizes of the managed range, controller-to-datapath command and status
// types, and the node/block index arithmetic of the buddy tree.
// ----------------------------------------------------------------------------
package ba_pkg;

  // Geometry of the managed range
  localparam int MIN_BLOCK_LOG2 = 7;
  localparam int SPACE_LOG2     = 17;
  localparam int HEADER_BYTES   = 8;
  localparam int NLEV           = SPACE_LOG2 - MIN_BLOCK_LOG2 + 1;
  localparam int TOP            = NLEV - 1;
  localparam int BLK_W          = SPACE_LOG2 - MIN_BLOCK_LOG2;
  localparam int NBLK           = 1 << BLK_W;
  localparam int NODE_W         = BLK_W + 1;
  localparam int LVL_W          = $clog2(NLEV);

  // Split bits are held as rows of one word each
  localparam int SB_BIT_W  = (BLK_W < 5) ? BLK_W : 5;
  localparam int SB_ROW_W  = BLK_W - SB_BIT_W;
  localparam int SB_WIDTH  = 1 << SB_BIT_W;
  localparam int SB_DEPTH  = 1 << SB_ROW_W;

  // Payload widths
  localparam int DATA_W = 32;
  localparam logic [DATA_W-1:0] BASE_RESET = 32'h0100_0000;

  // Item codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_FREE    = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_G_CHK,
    OP_FL_RD,
    OP_FL_WR,
    OP_G_ROOTFREE,
    OP_G_SHRINK0,
    OP_G_PUSHRIGHT,
    OP_G_SHRINK1,
    OP_POP,
    OP_DEC_B,
    OP_A_NODE,
    OP_A_SPLIT,
    OP_A_PUSHR,
    OP_A_DONE,
    OP_FAIL,
    OP_F_SETUP,
    OP_F_LVL,
    OP_F_BUDDY,
    OP_F_UP,
    OP_F_PUSH,
    OP_DONE0,
    OP_RM_RD,
    OP_RM_UPD,
    OP_PUSH1,
    OP_PUSH2
  } ba_op_t;

  typedef struct packed {
    ba_op_t op;
    logic   sel_b;     // list lookups indexed by the search level
  } ba_cmd_t;

  typedef struct packed {
    logic is_free;
    logic too_large;
    logic fa_null;
    logic off_out;
    logic grow_b;      // root must grow to reach level b
    logic grow_bm1;    // root must grow to reach level b-1
    logic par_bit;
    logic flip_val;
    logic ne_b;
    logic b_is_rl;
    logic b_zero;
    logic rl_zero;
    logic node_zero;
    logic b_lt_orig;
    logic out_free;
  } ba_stat_t;

  // Tree node of a block at a level
  function automatic logic [NODE_W-1:0] node_of(input logic [BLK_W-1:0] blk,
                                                input logic [LVL_W-1:0] lvl);
    logic [NODE_W-1:0] sh;
    logic [NODE_W-1:0] first;
    sh    = {1'b0, blk} >> (LVL_W'(TOP) - lvl);
    first = (NODE_W'(1) << lvl) - NODE_W'(1);
    return sh + first;
  endfunction

  // First smallest-block number covered by a node at a level
  function automatic logic [BLK_W-1:0] blk_of(input logic [NODE_W-1:0] node,
                                              input logic [LVL_W-1:0] lvl);
    logic [NODE_W-1:0] t;
    t = node + NODE_W'(1) - (NODE_W'(1) << lvl);
    return BLK_W'(t << (LVL_W'(TOP) - lvl));
  endfunction

endpackage

// ----- sv/ba_ifs.sv -----
// ----------------------------------------------------------------------------
// ba_ifs: channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ba_req_if import ba_pkg::*;;
  logic              valid;
  logic              ready;
  logic              command;
  logic [DATA_W-1:0] request_size;
  logic [DATA_W-1:0] free_address;
  modport source (output valid, command, request_size, free_address, input ready);
  modport sink   (input valid, command, request_size, free_address, output ready);
endinterface

interface ba_rsp_if import ba_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] address;
  logic              status;
  modport source (output valid, address, status, input ready);
  modport sink   (input valid, address, status, output ready);
endinterface

interface ba_cfg_if import ba_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- sv/ba_ram.sv -----
// ----------------------------------------------------------------------------
// ba_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (old data on a
// same-address collision).
// ----------------------------------------------------------------------------
module ba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ba_datapath.sv -----
// ----------------------------------------------------------------------------
// ba_datapath: buddy tree storage and arithmetic
// Free lists, split-bit and link RAMs, level/node registers and the result
// register, all driven by one micro-operation a cycle from the controller.
// ----------------------------------------------------------------------------
module ba_datapath import ba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ba_cmd_t           cmd,
  output ba_stat_t          st,
  input  logic              cfg_valid,
  input  logic [DATA_W-1:0] cfg_data,
  input  logic              in_command,
  input  logic [DATA_W-1:0] in_request_size,
  input  logic [DATA_W-1:0] in_free_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_address,
  output logic              out_status
);

  // Item and configuration registers
  logic [DATA_W-1:0] base;
  logic              cmd_r;
  logic [DATA_W-1:0] fa;
  logic              too_large;
  logic [LVL_W-1:0]  orig;

  // Walk registers
  logic [LVL_W-1:0]  b;
  logic [LVL_W-1:0]  rl;
  logic [BLK_W-1:0]  blk;
  logic [NODE_W-1:0] node;
  logic [LVL_W-1:0]  arg_lvl;
  logic [BLK_W-1:0]  arg_blk;
  logic [NODE_W-1:0] arg_node;
  logic              was_ne;
  logic [BLK_W-1:0]  old_back;
  logic              flip_val;

  // Free lists per level
  logic [BLK_W-1:0]  front [NLEV];
  logic [BLK_W-1:0]  back  [NLEV];
  logic [NLEV-1:0]   ne;
  logic [SB_DEPTH-1:0] sb_valid;

  // RAM ports
  logic                sb_we;
  logic [SB_WIDTH-1:0] sb_wd;
  logic [SB_WIDTH-1:0] sb_rd;
  logic                ln_we;
  logic [BLK_W-1:0]    ln_wa;
  logic [BLK_W-1:0]    ln_wd;
  logic [BLK_W-1:0]    ln_rd;
  logic                lp_we;
  logic [BLK_W-1:0]    lp_wa;
  logic [BLK_W-1:0]    lp_wd;
  logic [BLK_W-1:0]    lp_rd;
  logic                bl_we;
  logic [LVL_W-1:0]    bl_rd;

  // Derived values
  logic [DATA_W:0]     need_in;
  logic [LVL_W-1:0]    orig_c;
  logic [DATA_W-1:0]   off;
  logic [BLK_W-1:0]    off_blk;
  logic [LVL_W-1:0]    lidx;
  logic [LVL_W-1:0]    rl_m1;
  logic [BLK_W-1:0]    par;
  logic [SB_ROW_W-1:0] sb_row_i;
  logic [SB_BIT_W-1:0] sb_bit_i;
  logic [SB_WIDTH-1:0] sb_row;
  logic                par_bit;
  logic                rm_mid;
  logic [LVL_W-1:0]    bl_lvl;
  logic [NODE_W-1:0]   sib;
  logic [NODE_W-1:0]   parent;
  logic [NODE_W-1:0]   child;
  logic                res_load;

  // Request size to level
  always_comb begin
    need_in = {1'b0, in_request_size} + (DATA_W+1)'(HEADER_BYTES);
    orig_c  = '0;
    for (int k = NLEV - 1; k >= 0; k--) begin
      if (need_in <= ((DATA_W+1)'(1) << (MIN_BLOCK_LOG2 + k))) begin
        orig_c = LVL_W'(TOP - k);
      end
    end
  end

  assign off     = fa - DATA_W'(HEADER_BYTES) - base;
  assign off_blk = off[MIN_BLOCK_LOG2 +: BLK_W];
  assign lidx    = cmd.sel_b ? b : arg_lvl;
  assign rl_m1   = rl - LVL_W'(1);

  // Split bit addressed by the parent of arg_node
  assign par      = BLK_W'((arg_node - NODE_W'(1)) >> 1);
  assign sb_row_i = par[BLK_W-1:SB_BIT_W];
  assign sb_bit_i = par[SB_BIT_W-1:0];
  assign sb_row   = sb_valid[sb_row_i] ? sb_rd : '0;
  assign par_bit  = sb_row[sb_bit_i];
  assign sb_we    = (cmd.op == OP_FL_WR);
  assign sb_wd    = sb_row ^ (SB_WIDTH'(1) << sb_bit_i);

  // Node arithmetic
  assign bl_lvl = (bl_rd > LVL_W'(TOP)) ? LVL_W'(TOP) : bl_rd;
  assign sib    = ((node - NODE_W'(1)) ^ NODE_W'(1)) + NODE_W'(1);
  assign parent = (node - NODE_W'(1)) >> 1;
  assign child  = {node[NODE_W-2:0], 1'b1};

  // Unlink of a middle element
  assign rm_mid = ne[lidx] && (front[lidx] != arg_blk) && (back[lidx] != arg_blk);

  // Link RAM write selection
  always_comb begin
    ln_we = 1'b0;
    ln_wa = arg_blk;
    ln_wd = arg_blk;
    lp_we = 1'b0;
    lp_wa = arg_blk;
    lp_wd = arg_blk;
    case (cmd.op)
      OP_PUSH1: begin
        ln_we = 1'b1;
        lp_we = 1'b1;
        lp_wd = ne[lidx] ? back[lidx] : arg_blk;
      end
      OP_PUSH2: begin
        ln_we = was_ne;
        ln_wa = old_back;
      end
      OP_RM_UPD: begin
        ln_we = rm_mid;
        ln_wa = lp_rd;
        ln_wd = ln_rd;
        lp_we = rm_mid;
        lp_wa = ln_rd;
        lp_wd = lp_rd;
      end
      default: begin
      end
    endcase
  end

  assign bl_we    = (cmd.op == OP_A_DONE);
  assign res_load = (cmd.op == OP_A_DONE) || (cmd.op == OP_FAIL) || (cmd.op == OP_DONE0);

  // Storage
  ba_ram #(.WIDTH(SB_WIDTH), .DEPTH(SB_DEPTH)) u_sb (
    .clk(clk), .we(sb_we), .waddr(sb_row_i), .wdata(sb_wd), .raddr(sb_row_i), .rdata(sb_rd)
  );
  ba_ram #(.WIDTH(BLK_W), .DEPTH(NBLK)) u_ln (
    .clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(arg_blk), .rdata(ln_rd)
  );
  ba_ram #(.WIDTH(BLK_W), .DEPTH(NBLK)) u_lp (
    .clk(clk), .we(lp_we), .waddr(lp_wa), .wdata(lp_wd), .raddr(arg_blk), .rdata(lp_rd)
  );
  ba_ram #(.WIDTH(LVL_W), .DEPTH(NBLK)) u_bl (
    .clk(clk), .we(bl_we), .waddr(blk), .wdata(orig), .raddr(off_blk), .rdata(bl_rd)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= BASE_RESET;
    end else if (cfg_valid) begin
      base <= cfg_data;
    end
  end

  // List state, root level and split-row valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NLEV; l++) begin
        front[l] <= '0;
        back[l]  <= '0;
      end
      ne       <= NLEV'(1) << TOP;
      rl       <= LVL_W'(TOP);
      sb_valid <= '0;
    end else begin
      case (cmd.op)
        OP_FL_WR: sb_valid[sb_row_i] <= 1'b1;
        OP_G_SHRINK0, OP_G_SHRINK1: begin
          rl        <= rl_m1;
          ne[rl_m1] <= 1'b0;
        end
        OP_PUSH1: begin
          if (!ne[lidx]) begin
            front[lidx] <= arg_blk;
            ne[lidx]    <= 1'b1;
          end
          back[lidx] <= arg_blk;
        end
        OP_RM_UPD: begin
          if (ne[lidx]) begin
            if (front[lidx] == arg_blk && back[lidx] == arg_blk) begin
              ne[lidx] <= 1'b0;
            end else if (back[lidx] == arg_blk) begin
              back[lidx] <= lp_rd;
            end else if (front[lidx] == arg_blk) begin
              front[lidx] <= ln_rd;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_r     <= in_command;
        fa        <= in_free_address;
        too_large <= need_in > ((DATA_W+1)'(1) << SPACE_LOG2);
        orig      <= orig_c;
        b         <= orig_c;
      end
      OP_G_CHK: arg_node <= (NODE_W'(1) << rl) - NODE_W'(1);
      OP_FL_WR: flip_val <= ~par_bit;
      OP_G_ROOTFREE: begin
        arg_lvl <= rl;
        arg_blk <= '0;
      end
      OP_G_SHRINK0: begin
        arg_lvl <= rl_m1;
        arg_blk <= '0;
      end
      OP_G_PUSHRIGHT: begin
        arg_lvl <= rl;
        arg_blk <= BLK_W'(1) << (LVL_W'(TOP) - rl);
      end
      OP_G_SHRINK1: arg_node <= (NODE_W'(1) << rl_m1) - NODE_W'(1);
      OP_POP: begin
        arg_lvl <= b;
        arg_blk <= back[lidx];
        blk     <= back[lidx];
      end
      OP_DEC_B: b <= b - LVL_W'(1);
      OP_A_NODE: begin
        node     <= node_of(blk, b);
        arg_node <= node_of(blk, b);
      end
      OP_A_SPLIT: begin
        node     <= child;
        arg_node <= child;
        b        <= b + LVL_W'(1);
      end
      OP_A_PUSHR: begin
        arg_lvl <= b;
        arg_blk <= blk_of(node + NODE_W'(1), b);
      end
      OP_F_SETUP: blk <= off_blk;
      OP_F_LVL: begin
        b        <= bl_lvl;
        node     <= node_of(blk, bl_lvl);
        arg_node <= node_of(blk, bl_lvl);
      end
      OP_F_BUDDY: begin
        arg_lvl <= b;
        arg_blk <= blk_of(sib, b);
      end
      OP_F_UP: begin
        node     <= parent;
        arg_node <= parent;
        b        <= b - LVL_W'(1);
      end
      OP_F_PUSH: begin
        arg_lvl <= b;
        arg_blk <= blk_of(node, b);
      end
      OP_PUSH1: begin
        was_ne   <= ne[lidx];
        old_back <= back[lidx];
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_A_DONE: begin
        out_address <= base + (DATA_W'(blk) << MIN_BLOCK_LOG2) + DATA_W'(HEADER_BYTES);
        out_status  <= STATUS_OK;
      end
      OP_FAIL: begin
        out_address <= '0;
        out_status  <= STATUS_FAIL;
      end
      OP_DONE0: begin
        out_address <= '0;
        out_status  <= STATUS_OK;
      end
      default: begin
      end
    endcase
  end

  // Status to the controller
  always_comb begin
    st.is_free   = (cmd_r == CMD_FREE);
    st.too_large = too_large;
    st.fa_null   = (fa == '0);
    st.off_out   = |off[DATA_W-1:SPACE_LOG2];
    st.grow_b    = (b < rl) && (rl != '0);
    st.grow_bm1  = (b <= rl) && (rl != '0);
    st.par_bit   = par_bit;
    st.flip_val  = flip_val;
    st.ne_b      = ne[lidx];
    st.b_is_rl   = (b == rl);
    st.b_zero    = (b == '0);
    st.rl_zero   = (rl == '0);
    st.node_zero = (node == '0);
    st.b_lt_orig = (b < orig);
    st.out_free  = !out_valid || out_ready;
  end

endmodule

// ----- sv/ba_ctrl.sv -----
// ----------------------------------------------------------------------------
// ba_ctrl: allocator sequencer
// One-hot state machine that walks allocation, tree growth and free merges,
// calling remove, push and flip sequences with a return state.
// ----------------------------------------------------------------------------
module ba_ctrl import ba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ba_stat_t st,
  output ba_cmd_t  cmd
);

  typedef enum logic [29:0] {
    S_IDLE     = 30'd1 << 0,
    S_DISPATCH = 30'd1 << 1,
    S_A_LOOP   = 30'd1 << 2,
    S_G_TEST   = 30'd1 << 3,
    S_G_RD     = 30'd1 << 4,
    S_G_BR     = 30'd1 << 5,
    S_G_SH0    = 30'd1 << 6,
    S_G_SH1    = 30'd1 << 7,
    S_G_FL     = 30'd1 << 8,
    S_RM_RD    = 30'd1 << 9,
    S_RM_UPD   = 30'd1 << 10,
    S_PUSH1    = 30'd1 << 11,
    S_PUSH2    = 30'd1 << 12,
    S_FL_RD    = 30'd1 << 13,
    S_FL_WR    = 30'd1 << 14,
    S_A_POP    = 30'd1 << 15,
    S_A_POP2   = 30'd1 << 16,
    S_A_NODE   = 30'd1 << 17,
    S_A_NFL    = 30'd1 << 18,
    S_A_SPL    = 30'd1 << 19,
    S_A_PR     = 30'd1 << 20,
    S_A_DONE   = 30'd1 << 21,
    S_FAIL     = 30'd1 << 22,
    S_DONE0    = 30'd1 << 23,
    S_F_SETUP  = 30'd1 << 24,
    S_F_LVL    = 30'd1 << 25,
    S_F_LOOP   = 30'd1 << 26,
    S_F_CHK    = 30'd1 << 27,
    S_F_UP     = 30'd1 << 28,
    S_F_PUSH   = 30'd1 << 29
  } ba_state_t;

  ba_state_t state, state_next;
  ba_state_t ret, ret_next;     // return of remove/push/flip
  ba_state_t gret, gret_next;   // return of tree growth
  logic      gm, gm_next;       // grow towards b-1 instead of b

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      gret  <= S_IDLE;
      gm    <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      gret  <= gret_next;
      gm    <= gm_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and command
  always_comb begin
    state_next = state;
    ret_next   = ret;
    gret_next  = gret;
    gm_next    = gm;
    cmd.op     = OP_NONE;
    cmd.sel_b  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.is_free) begin
          state_next = (st.fa_null || st.off_out) ? S_DONE0 : S_F_SETUP;
        end else begin
          state_next = st.too_large ? S_FAIL : S_A_LOOP;
        end
      end

      // Allocation search
      S_A_LOOP: begin
        gm_next    = 1'b0;
        gret_next  = S_A_POP;
        state_next = S_G_TEST;
      end
      S_A_POP, S_A_POP2: begin
        cmd.sel_b = 1'b1;
        if (st.ne_b) begin
          cmd.op     = OP_POP;
          ret_next   = S_A_NODE;
          state_next = S_RM_RD;
        end else if (state == S_A_POP && st.b_is_rl && !st.b_zero) begin
          gm_next    = 1'b1;
          gret_next  = S_A_POP2;
          state_next = S_G_TEST;
        end else if (st.b_zero) begin
          state_next = S_FAIL;
        end else begin
          cmd.op     = OP_DEC_B;
          state_next = S_A_LOOP;
        end
      end
      S_A_NODE: begin
        cmd.op     = OP_A_NODE;
        state_next = S_A_NFL;
      end
      S_A_NFL: begin
        if (st.node_zero) begin
          state_next = S_A_SPL;
        end else begin
          ret_next   = S_A_SPL;
          state_next = S_FL_RD;
        end
      end
      S_A_SPL: begin
        if (st.b_lt_orig) begin
          cmd.op     = OP_A_SPLIT;
          ret_next   = S_A_PR;
          state_next = S_FL_RD;
        end else begin
          state_next = S_A_DONE;
        end
      end
      S_A_PR: begin
        cmd.op     = OP_A_PUSHR;
        ret_next   = S_A_SPL;
        state_next = S_PUSH1;
      end

      // Tree growth
      S_G_TEST: begin
        if (gm ? st.grow_bm1 : st.grow_b) begin
          cmd.op     = OP_G_CHK;
          state_next = S_G_RD;
        end else begin
          state_next = gret;
        end
      end
      S_G_RD: begin
        cmd.op     = OP_FL_RD;
        state_next = S_G_BR;
      end
      S_G_BR: begin
        if (!st.par_bit) begin
          cmd.op     = OP_G_ROOTFREE;
          ret_next   = S_G_SH0;
          state_next = S_RM_RD;
        end else begin
          cmd.op     = OP_G_PUSHRIGHT;
          ret_next   = S_G_SH1;
          state_next = S_PUSH1;
        end
      end
      S_G_SH0: begin
        cmd.op     = OP_G_SHRINK0;
        ret_next   = S_G_TEST;
        state_next = S_PUSH1;
      end
      S_G_SH1: begin
        cmd.op     = OP_G_SHRINK1;
        state_next = S_G_FL;
      end
      S_G_FL: begin
        if (st.rl_zero) begin
          state_next = S_G_TEST;
        end else begin
          ret_next   = S_G_TEST;
          state_next = S_FL_RD;
        end
      end

      // Shared list and split-bit sequences
      S_RM_RD: begin
        cmd.op     = OP_RM_RD;
        state_next = S_RM_UPD;
      end
      S_RM_UPD: begin
        cmd.op     = OP_RM_UPD;
        state_next = ret;
      end
      S_PUSH1: begin
        cmd.op     = OP_PUSH1;
        state_next = S_PUSH2;
      end
      S_PUSH2: begin
        cmd.op     = OP_PUSH2;
        state_next = ret;
      end
      S_FL_RD: begin
        cmd.op     = OP_FL_RD;
        state_next = S_FL_WR;
      end
      S_FL_WR: begin
        cmd.op     = OP_FL_WR;
        state_next = ret;
      end

      // Free and merge
      S_F_SETUP: begin
        cmd.op     = OP_F_SETUP;
        state_next = S_F_LVL;
      end
      S_F_LVL: begin
        cmd.op     = OP_F_LVL;
        state_next = S_F_LOOP;
      end
      S_F_LOOP: begin
        if (!st.b_zero) begin
          ret_next   = S_F_CHK;
          state_next = S_FL_RD;
        end else begin
          state_next = S_F_PUSH;
        end
      end
      S_F_CHK: begin
        if (st.flip_val || st.b_is_rl) begin
          state_next = S_F_PUSH;
        end else begin
          cmd.op     = OP_F_BUDDY;
          ret_next   = S_F_UP;
          state_next = S_RM_RD;
        end
      end
      S_F_UP: begin
        cmd.op     = OP_F_UP;
        state_next = S_F_LOOP;
      end
      S_F_PUSH: begin
        cmd.op     = OP_F_PUSH;
        ret_next   = S_DONE0;
        state_next = S_PUSH1;
      end

      // Results wait for a free output slot
      S_A_DONE: begin
        if (st.out_free) begin
          cmd.op     = OP_A_DONE;
          state_next = S_IDLE;
        end
      end
      S_FAIL: begin
        if (st.out_free) begin
          cmd.op     = OP_FAIL;
          state_next = S_IDLE;
        end
      end
      S_DONE0: begin
        if (st.out_free) begin
          cmd.op     = OP_DONE0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/buddy_allocator_top.sv -----
// ----------------------------------------------------------------------------
// buddy_allocator_top: buddy memory allocator
// Allocates and frees power-of-two blocks of a 128 KiB range above a
// programmable base address.
//
//   channel  dir  payload                                 transaction
//   cfg      in   data                                    base address write
//   req      in   command, request_size, free_address     one alloc or free
//   rsp      out  address, status                         one per request
//
// One request at a time. Allocation time grows with each level searched
// without a free block, each tree growth step and each split level; a free
// grows with each merge level. A null or out-of-range free, or a too-large
// request, is answered without a tree walk. The time is set by the sequencer
// stepping one tree level at a time through the split-bit and link RAMs.
// The next request is taken in the cycle after the response is loaded.
// Reset is synchronous and takes effect at once: split-bit rows carry valid
// flops, so no clearing pass. A pending response does not block acceptance
// of the next request; a new result waits only for the response slot.
// ----------------------------------------------------------------------------
module buddy_allocator_top import ba_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  ba_cfg_if.sink  cfg,
  ba_req_if.sink  req,
  ba_rsp_if.source rsp
);

  ba_cmd_t  cmd;
  ba_stat_t st;
  logic     in_ready;

  // Configuration is always taken
  assign cfg.ready = 1'b1;
  assign req.ready = in_ready;

  ba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ba_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .cfg_valid       (cfg.valid),
    .cfg_data        (cfg.data),
    .in_command      (req.command),
    .in_request_size (req.request_size),
    .in_free_address (req.free_address),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_address     (rsp.address),
    .out_status      (rsp.status)
  );

endmodule
